/* sv/array_list_stack_engine_core_macros.svh */
// Assertion helpers for the list/stack engine.
`ifndef ARRAY_LIST_STACK_ENGINE_CORE_MACROS_SVH
`define ARRAY_LIST_STACK_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ALSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("alse: assertion failed");
// next-cycle implication
`define ALSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("alse: assertion failed");
`else
`define ALSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ALSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/alse_pkg.sv */
`default_nettype none
package alse_pkg;

	localparam int DEPTH  = 128;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	// compare width: holds count+1 and any 8-bit position
	localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_READ   = 3'd2,
		REQ_PUSH   = 3'd3,
		REQ_POP    = 3'd4,
		REQ_SEARCH = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADPOS   = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHUP,
		S_WALK,
		S_DRAIN,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [31:0]       wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] rd;
		logic [7:0]  found;
		logic [7:0]  count;
	} res_t;

endpackage
`default_nettype wire

/* sv/alse_store.sv */
`default_nettype none
module alse_store (
	input  wire logic              clk,
	input  wire alse_pkg::mem_req_t req,
	output logic [31:0]            rdata
);
	import alse_pkg::*;

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* sv/alse_ctrl.sv */
`default_nettype none
`include "array_list_stack_engine_core_macros.svh"
module alse_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         req_type,
	input  wire logic [7:0]         position,
	input  wire logic [31:0]        value,
	output alse_pkg::mem_req_t      mem,
	input  wire logic [31:0]        rdata,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output alse_pkg::res_t          res
);
	import alse_pkg::*;

	state_t            state_q, state_d;
	req_t              op_q, op_d;
	logic [7:0]        pos_q, pos_d;
	logic [31:0]       val_q, val_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [ADDR_W-1:0] last_q, last_d;
	logic [ADDR_W-1:0] start_q, start_d;
	logic [ADDR_W-1:0] end_q, end_d;
	logic              pend_q, pend_d;
	status_t           status_q, status_d;
	logic [31:0]       rd_q, rd_d;
	logic [7:0]        found_q, found_d;

	logic [CMP_W-1:0]  n_ext, p_ext, pm1, nm1, np1, found_ext, cnt_ext;
	logic              full, empty, bad_rd, bad_ins;

	assign n_ext     = CMP_W'(count_q);
	assign p_ext     = CMP_W'(pos_q);
	assign pm1       = p_ext - CMP_W'(1);
	assign nm1       = n_ext - CMP_W'(1);
	assign np1       = n_ext + CMP_W'(1);
	assign found_ext = CMP_W'(last_q) + CMP_W'(1);
	assign cnt_ext   = CMP_W'(count_q);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign bad_rd    = (p_ext == '0) || (p_ext > n_ext);
	assign bad_ins   = (p_ext == '0) || (p_ext > np1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		pos_q    <= pos_d;
		val_q    <= val_d;
		addr_q   <= addr_d;
		last_q   <= last_d;
		start_q  <= start_d;
		end_q    <= end_d;
		status_q <= status_d;
		rd_q     <= rd_d;
		found_q  <= found_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		pos_d     = pos_q;
		val_d     = val_q;
		count_d   = count_q;
		addr_d    = addr_q;
		last_d    = last_q;
		start_d   = start_q;
		end_d     = end_q;
		pend_d    = pend_q;
		status_d  = status_q;
		rd_d      = rd_q;
		found_d   = found_q;
		mem       = '0;
		mem.raddr = addr_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = req_t'(req_type);
					pos_d    = position;
					val_d    = value;
					status_d = ST_OK;
					rd_d     = '0;
					found_d  = '0;
					pend_d   = 1'b0;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (op_q) inside
					REQ_INSERT: begin
						if (bad_ins) begin
							status_d = ST_BADPOS;
						end else if (full) begin
							status_d = ST_FULL;
						end else if (p_ext == np1) begin
							end_d   = pm1[ADDR_W-1:0];
							state_d = S_WRITE;
						end else begin
							addr_d  = nm1[ADDR_W-1:0];
							end_d   = pm1[ADDR_W-1:0];
							state_d = S_SHUP;
						end
					end
					REQ_PUSH: begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							end_d   = n_ext[ADDR_W-1:0];
							state_d = S_WRITE;
						end
					end
					REQ_DELETE, REQ_READ: begin
						if (bad_rd) begin
							status_d = ST_BADPOS;
						end else begin
							addr_d  = pm1[ADDR_W-1:0];
							start_d = pm1[ADDR_W-1:0];
							end_d   = (op_q == REQ_DELETE) ? nm1[ADDR_W-1:0]
								: pm1[ADDR_W-1:0];
							state_d = S_WALK;
						end
					end
					REQ_POP: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							addr_d  = nm1[ADDR_W-1:0];
							start_d = nm1[ADDR_W-1:0];
							end_d   = nm1[ADDR_W-1:0];
							state_d = S_WALK;
						end
					end
					REQ_SEARCH: begin
						if (empty) begin
							status_d = ST_EMPTY;
						end else begin
							addr_d   = '0;
							start_d  = '0;
							end_d    = nm1[ADDR_W-1:0];
							status_d = ST_NOTFOUND;
							state_d  = S_WALK;
						end
					end
					default: ;
				endcase
			end
			S_SHUP: begin
				pend_d = 1'b1;
				last_d = addr_q;
				if (addr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					addr_d = addr_q - ADDR_W'(1);
				end
			end
			S_WALK: begin
				pend_d = 1'b1;
				last_d = addr_q;
				if (addr_q == end_q) begin
					state_d = S_DRAIN;
				end else begin
					addr_d = addr_q + ADDR_W'(1);
				end
			end
			S_DRAIN: begin
				pend_d = 1'b0;
				if (op_q == REQ_INSERT) begin
					state_d = S_WRITE;
				end else begin
					if (op_q == REQ_DELETE || op_q == REQ_POP) begin
						count_d = count_q - CNT_W'(1);
					end
					state_d = S_DONE;
				end
			end
			S_WRITE: begin
				mem.we    = 1'b1;
				mem.waddr = end_q;
				mem.wdata = val_q;
				count_d   = count_q + CNT_W'(1);
				state_d   = S_DONE;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// read data for the address issued last cycle
		if (pend_q && (state_q == S_SHUP || state_q == S_WALK || state_q == S_DRAIN)) begin
			unique case (op_q) inside
				REQ_INSERT: begin
					mem.we    = 1'b1;
					mem.waddr = last_q + ADDR_W'(1);
					mem.wdata = rdata;
				end
				REQ_DELETE: begin
					if (last_q == start_q) begin
						rd_d = rdata;
					end else begin
						mem.we    = 1'b1;
						mem.waddr = last_q - ADDR_W'(1);
						mem.wdata = rdata;
					end
				end
				REQ_READ, REQ_POP: begin
					rd_d = rdata;
				end
				REQ_SEARCH: begin
					if (rdata == val_q) begin
						status_d = ST_OK;
						found_d  = found_ext[7:0];
						state_d  = S_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	assign res.status = status_q;
	assign res.rd     = rd_q;
	assign res.found  = found_q;
	assign res.count  = cnt_ext[7:0];

	`ALSE_ASSERT_NEXT(a_done_hold, clk, arst_n, state_q == S_DONE && !res_ready, state_q == S_DONE)
	`ALSE_ASSERT_IMPL(a_we_state, clk, arst_n, mem.we, state_q == S_SHUP || state_q == S_WALK || state_q == S_DRAIN || state_q == S_WRITE)
	`ALSE_ASSERT_IMPL(a_cnt_move, clk, arst_n, count_q != $past(count_q), $past(state_q) == S_WRITE || $past(state_q) == S_DRAIN)
	`ALSE_ASSERT_IMPL(a_cnt_max, clk, arst_n, res_valid, n_ext <= CMP_W'(DEPTH))

endmodule
`default_nettype wire

/* sv/array_list_stack_engine_core.sv */
// Array-backed ordered list with stack access.
// Input channel (in_valid/in_ready) carries one request per beat: req_type,
// 1-based position and value. Output channel (out_valid/out_ready) returns
// one result beat per request: status, read_value, found_position and
// entry_count (entries held after the request).
// Steps after accept: rejected requests and unused codes go from decode to
// the result; push and insert at count+1 do one write; read and pop do one
// read and a drain. Insert at position p moves count-p+1 entries; delete at
// p walks count-p+1 entries; search scans entries up to the first match.
// The walk is bounded by the single read and write port of the entry memory
// and one address stepper/compare.
// One request is in flight at a time; in_ready comes back in the cycle after
// the result leaves the sequencer. A finished result sits in an output
// register, so the next request is accepted while out_valid waits; if the
// receiver keeps out_ready low the sequencer holds its next result and stops
// taking beats.
// Reset (arst_n low) empties the list and drops any pending result. The
// entry memory is not cleared: only counted positions are ever read.
`default_nettype none
`include "array_list_stack_engine_core_macros.svh"
module array_list_stack_engine_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         req_type,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      read_value,
	output logic [7:0]              found_position,
	output logic [7:0]              entry_count
);
	import alse_pkg::*;

	mem_req_t    mem;
	logic [31:0] rdata;
	logic        res_valid, res_ready;
	res_t        res;

	logic        out_valid_q;
	res_t        res_q;

	alse_store u_store (
		.clk   (clk),
		.req   (mem),
		.rdata (rdata)
	);

	alse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.position  (position),
		.value     (value),
		.mem       (mem),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: free when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign read_value     = res_q.rd;
	assign found_position = res_q.found;
	assign entry_count    = res_q.count;

	`ALSE_ASSERT_NEXT(a_busy_after_acc, clk, arst_n, in_valid && in_ready, !in_ready)
	`ALSE_ASSERT_NEXT(a_res_load, clk, arst_n, res_valid && res_ready, out_valid)
	`ALSE_ASSERT_IMPL(a_res_wait, clk, arst_n, res_valid && !res_ready, out_valid && !out_ready)

endmodule
`default_nettype wire
